### src/hec_pkg.sv
// Hamming encode/correct package: constants, codes and elaboration helpers.
// Used by hamming_encode_correct; no dependencies.
package hec_pkg;

  localparam int MAX_DATA_BITS   = 57;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 6;
  localparam int DATA_LENGTH_RST = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DATA_LENGTH = 2'd0,
    CFG_PARITY_ODD  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CORRECTED = 2'd1,
    STATUS_BEYOND    = 2'd2
  } status_e;

  function automatic int par_count(int n);
    int p;
    p = 1;
    while (n + p + 1 > (1 << p)) p++;
    return p;
  endfunction

  function automatic bit is_pow2(int j);
    return (j != 0) && ((j & (j - 1)) == 0);
  endfunction

  // 0-based data bit index held at codeword position j (j not a power of two)
  function automatic int data_idx(int j);
    int cnt;
    cnt = 0;
    for (int m = 1; m <= j; m++) begin
      if (is_pow2(m)) cnt++;
    end
    return j - cnt - 1;
  endfunction

  // bit position of the single set bit of a power of two
  function automatic int log2_exact(int j);
    int r;
    r = 0;
    for (int b = 0; b < 31; b++) begin
      if (j == (1 << b)) r = b;
    end
    return r;
  endfunction

endpackage

### src/hamming_encode_correct.sv
// Hamming single-error-correcting coder, variable length, even or odd parity.
// An accepted start reaches the done_o strobe through the valid registers v1_q, v2_q and v3_q.
// Throughput: one transaction per cycle; busy_o never rises and the three
// register stages (place/mask, parity XOR trees, insert/correct/extract) run freely.
// Reset: clears the valid pipeline; data_length = 4, even parity.
// Depends on hec_pkg.
module hamming_encode_correct #(
  parameter int MAX_DATA_BITS = hec_pkg::MAX_DATA_BITS,
  localparam int PAR    = hec_pkg::par_count(MAX_DATA_BITS),
  localparam int CODE_W = MAX_DATA_BITS + PAR
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic [MAX_DATA_BITS-1:0]       data_word_i,
  input  logic [CODE_W-1:0]              received_code_i,
  output logic                           done_o,
  output logic [CODE_W-1:0]              code_out_o,
  output logic [MAX_DATA_BITS-1:0]       data_out_o,
  output logic [PAR-1:0]                 syndrome_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hec_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hec_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LEN_W = $clog2(CODE_W + 1);
  localparam int CMP_W = (PAR > LEN_W) ? PAR : LEN_W;
  localparam int DW    = hec_pkg::CFG_DATA_W;

  function automatic logic [DW-1:0] f_eff_n(logic [DW-1:0] raw);
    logic [DW-1:0] n;
    n = raw;
    if (raw == '0) n = DW'(1);
    else if (int'(raw) > MAX_DATA_BITS) n = DW'(MAX_DATA_BITS);
    return n;
  endfunction

  function automatic logic [2:0] f_par(logic [DW-1:0] raw);
    logic [DW-1:0] n;
    logic [2:0]    p;
    n = f_eff_n(raw);
    p = 3'd6;
    for (int i = 6; i >= 1; i--) begin
      if (int'(n) + i + 1 <= (1 << i)) p = 3'(i);
    end
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] f_len(logic [DW-1:0] raw);
    return LEN_W'(int'(f_eff_n(raw)) + int'(f_par(raw)));
  endfunction

  function automatic logic [MAX_DATA_BITS-1:0] f_nmask(logic [DW-1:0] raw);
    logic [MAX_DATA_BITS-1:0] m;
    for (int k = 0; k < MAX_DATA_BITS; k++) m[k] = (k < int'(f_eff_n(raw)));
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] f_lmask(logic [DW-1:0] raw);
    logic [CODE_W-1:0] m;
    for (int j = 0; j < CODE_W; j++) m[j] = (j < int'(f_len(raw)));
    return m;
  endfunction

  function automatic logic [PAR-1:0] f_pen(logic [DW-1:0] raw);
    logic [PAR-1:0] m;
    for (int i = 0; i < PAR; i++) m[i] = (i < int'(f_par(raw)));
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] f_cover(int i);
    logic [CODE_W-1:0] m;
    for (int j = 1; j <= CODE_W; j++) m[j-1] = ((j >> i) & 1) != 0;
    return m;
  endfunction

  // configuration
  logic                     odd_q;
  logic [LEN_W-1:0]         len_q;
  logic [MAX_DATA_BITS-1:0] nmask_q;
  logic [CODE_W-1:0]        lmask_q;
  logic [PAR-1:0]           pen_q;
  logic                     cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q   <= 1'b0;
      len_q   <= f_len(DW'(hec_pkg::DATA_LENGTH_RST));
      nmask_q <= f_nmask(DW'(hec_pkg::DATA_LENGTH_RST));
      lmask_q <= f_lmask(DW'(hec_pkg::DATA_LENGTH_RST));
      pen_q   <= f_pen(DW'(hec_pkg::DATA_LENGTH_RST));
    end else if (cfg_we) begin
      if (cfg_addr_i == hec_pkg::CFG_DATA_LENGTH) begin
        len_q   <= f_len(cfg_data_i);
        nmask_q <= f_nmask(cfg_data_i);
        lmask_q <= f_lmask(cfg_data_i);
        pen_q   <= f_pen(cfg_data_i);
      end else if (cfg_addr_i == hec_pkg::CFG_PARITY_ODD) begin
        odd_q <= cfg_data_i[0];
      end
    end
  end

  // handshake
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // stage 1: place data bits or mask received word
  logic [MAX_DATA_BITS-1:0] dmask;
  logic [CODE_W-1:0]        scat;
  logic [CODE_W-1:0]        word1_d;
  logic [CODE_W-1:0]        word1_q;
  logic                     act1_q, v1_q;

  assign dmask = data_word_i & nmask_q;

  for (genvar j = 1; j <= CODE_W; j++) begin : g_scat
    if (hec_pkg::is_pow2(j)) begin : g_par
      assign scat[j-1] = 1'b0;
    end else begin : g_dat
      assign scat[j-1] = dmask[hec_pkg::data_idx(j)];
    end
  end

  assign word1_d = action_i ? (received_code_i & lmask_q) : scat;

  // stage 2: parity / syndrome XOR trees
  logic [PAR-1:0]    chk_d;
  logic [PAR-1:0]    syn2_q;
  logic [CODE_W-1:0] word2_q;
  logic              act2_q, v2_q;

  for (genvar i = 0; i < PAR; i++) begin : g_chk
    assign chk_d[i] = ((^(word1_q & f_cover(i))) ^ odd_q) & pen_q[i];
  end

  // stage 3: insert parity, or correct and extract
  logic [CODE_W-1:0]        par_vec;
  logic [CODE_W-1:0]        flip;
  logic [CODE_W-1:0]        corr;
  logic [MAX_DATA_BITS-1:0] gath;
  hec_pkg::status_e         status_d;
  logic [CODE_W-1:0]        code_d;
  logic [MAX_DATA_BITS-1:0] data_d;
  logic [PAR-1:0]           syn_d;
  logic                     v3_q;

  for (genvar j = 1; j <= CODE_W; j++) begin : g_pos
    assign flip[j-1] = (syn2_q == PAR'(j));
    if (hec_pkg::is_pow2(j)) begin : g_par
      assign par_vec[j-1] = syn2_q[hec_pkg::log2_exact(j)];
    end else begin : g_dat
      assign par_vec[j-1] = 1'b0;
      assign gath[hec_pkg::data_idx(j)] = corr[j-1];
    end
  end

  always_comb begin
    status_d = hec_pkg::STATUS_OK;
    if (syn2_q == '0) status_d = hec_pkg::STATUS_OK;
    else if (CMP_W'(syn2_q) > CMP_W'(len_q)) status_d = hec_pkg::STATUS_BEYOND;
    else status_d = hec_pkg::STATUS_CORRECTED;
  end

  assign corr = (status_d == hec_pkg::STATUS_CORRECTED) ? (word2_q ^ flip) : word2_q;

  always_comb begin
    if (act2_q) begin
      code_d = corr;
      data_d = gath;
      syn_d  = syn2_q;
    end else begin
      code_d = word2_q | par_vec;
      data_d = '0;
      syn_d  = '0;
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word1_q <= word1_d;
      act1_q  <= action_i;
    end
    if (v1_q) begin
      word2_q <= word1_q;
      syn2_q  <= chk_d;
      act2_q  <= act1_q;
    end
    if (v2_q) begin
      code_out_o <= code_d;
      data_out_o <= data_d;
      syndrome_o <= syn_d;
      status_o   <= act2_q ? status_d : hec_pkg::STATUS_OK;
    end
  end

  assign done_o = v3_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("transaction did not complete in 3 cycles");

  a_beyond_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == hec_pkg::STATUS_BEYOND) |-> syndrome_o != '0)
    else $error("beyond-codeword status with zero syndrome");

  a_corr_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == hec_pkg::STATUS_CORRECTED) |-> syndrome_o != '0)
    else $error("corrected status with zero syndrome");

  a_zero_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (syndrome_o == '0) |-> status_o == hec_pkg::STATUS_OK)
    else $error("zero syndrome with error status");

endmodule
